/* rtl/pecp_pkg.sv */
// Shared constants, codes and character helpers for the path element parser.
package pecp_pkg;

  // Characters of the element grammar
  localparam logic [7:0] CH_PERCENT = 8'h25;  // '%'
  localparam logic [7:0] CH_DOLLAR  = 8'h24;  // '$'
  localparam logic [7:0] CH_DOT     = 8'h2E;  // '.'
  localparam logic [7:0] CH_UNDER   = 8'h5F;  // '_'
  localparam logic [7:0] CH_LBRACK  = 8'h5B;  // '['
  localparam logic [7:0] CH_RBRACK  = 8'h5D;  // ']'
  localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CH_SEVEN   = 8'h37;  // '7'
  localparam logic [7:0] CH_NINE    = 8'h39;  // '9'
  localparam logic [7:0] CH_X       = 8'h78;  // 'x'
  localparam logic [7:0] CH_LA      = 8'h61;  // 'a'
  localparam logic [7:0] CH_LF      = 8'h66;  // 'f'
  localparam logic [7:0] CH_LZ      = 8'h7A;  // 'z'
  localparam logic [7:0] CH_UA      = 8'h41;  // 'A'
  localparam logic [7:0] CH_UF      = 8'h46;  // 'F'
  localparam logic [7:0] CH_UZ      = 8'h5A;  // 'Z'

  // Hex letters map to their low nibble plus this offset
  localparam logic [3:0] HEX_LETTER_OFS = 4'd9;

  // Array suffix modes
  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_INDEX  = 2'd1,
    MODE_TAIL   = 2'd2,
    MODE_APPEND = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SYNTAX   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

/* rtl/path_element_char_parser_unit.sv */
// Top level of the path element parser: character state machine and result register.
//
// Parses one path element, one ASCII character per word, and returns one
// result word per input word: name characters are echoed as they arrive, and
// the word flagged last also carries the sticky status, bookmark flag, array
// mode and parsed index, after which all state returns to its reset value.
// The block takes one word every cycle while in_stall is low; a result appears
// in the cycle after its input is accepted. The cycle path is the character
// decoder plus one shift-add step of the index accumulator (x8, x10 or x16 plus
// a digit) with its overflow check. The result register holds a word while
// out_stall is high, and in_stall follows it so no word is dropped.
module path_element_char_parser_unit #(
  parameter int INDEX_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  ch,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        name_valid,
  output logic [7:0]  name_char,
  output logic        done_res,
  output logic [1:0]  status,
  output logic        bookmark,
  output logic [1:0]  suffix_mode,
  output logic [31:0] index_value
);

  localparam int ExtBits = INDEX_BITS + 4;

  typedef enum logic [3:0] {
    PH_START, PH_FIRSTCHAR, PH_BODY, PH_DOT, PH_OPEN,
    PH_CLOSE, PH_BASE, PH_INDEX, PH_DONE, PH_HALT
  } phase_t;

  typedef enum logic [1:0] {
    RADIX_DEC, RADIX_OCT, RADIX_HEX
  } radix_t;

  phase_t                  phase, phase_next;
  radix_t                  radix, radix_next;
  logic [INDEX_BITS-1:0]   index_acc, index_acc_next;
  pecp_pkg::mode_t         mode_reg, mode_next;
  logic                    bookmark_reg, bookmark_next;
  logic                    name_seen, name_seen_next;
  pecp_pkg::status_t       error_code, error_next;

  logic                    accept;
  logic                    echo;
  logic                    do_fail;
  pecp_pkg::status_t       fail_code;

  // Digit decode for the index phase
  logic                    dig_ok;
  logic [3:0]              dig_val;
  logic [ExtBits-1:0]      acc_ext, acc_scaled, acc_sum;
  logic                    acc_ovf;

  // Summary fields for the result word
  logic [1:0]              res_status;
  logic                    res_bookmark;
  logic [1:0]              res_mode;
  logic [31:0]             res_index;
  logic [63:0]             acc_wide;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Valid digit in the current radix and its value
  always_comb begin
    dig_ok  = 1'b0;
    dig_val = ch[3:0];
    unique case (radix)
      RADIX_DEC: dig_ok = pecp_pkg::is_digit(ch);
      RADIX_OCT: dig_ok = (ch >= pecp_pkg::CH_ZERO) && (ch <= pecp_pkg::CH_SEVEN);
      RADIX_HEX: begin
        if (pecp_pkg::is_digit(ch)) begin
          dig_ok = 1'b1;
        end else if (((ch >= pecp_pkg::CH_LA) && (ch <= pecp_pkg::CH_LF)) ||
                     ((ch >= pecp_pkg::CH_UA) && (ch <= pecp_pkg::CH_UF))) begin
          dig_ok  = 1'b1;
          dig_val = ch[3:0] + pecp_pkg::HEX_LETTER_OFS;
        end
      end
      default: dig_ok = 1'b0;
    endcase
  end

  // Shift-add accumulate step; overflow when any bit lands above the index width
  always_comb begin
    acc_ext = ExtBits'(index_acc);
    unique case (radix)
      RADIX_DEC: acc_scaled = (acc_ext << 3) + (acc_ext << 1);
      RADIX_OCT: acc_scaled = acc_ext << 3;
      RADIX_HEX: acc_scaled = acc_ext << 4;
      default:   acc_scaled = acc_ext;
    endcase
    acc_sum = acc_scaled + ExtBits'(dig_val);
    acc_ovf = |acc_sum[ExtBits-1:INDEX_BITS];
  end

  // Character state machine
  always_comb begin
    phase_next     = phase;
    radix_next     = radix;
    index_acc_next = index_acc;
    mode_next      = mode_reg;
    bookmark_next  = bookmark_reg;
    error_next     = error_code;
    echo           = 1'b0;
    do_fail        = 1'b0;
    fail_code      = pecp_pkg::ST_SYNTAX;

    unique case (phase)
      PH_START: begin
        if (ch == pecp_pkg::CH_PERCENT) begin
          echo       = 1'b1;
          phase_next = PH_FIRSTCHAR;
        end else if (ch == pecp_pkg::CH_DOLLAR) begin
          bookmark_next = 1'b1;
          phase_next    = PH_FIRSTCHAR;
        end else if (pecp_pkg::is_alpha(ch) || ch == pecp_pkg::CH_UNDER) begin
          echo       = 1'b1;
          phase_next = PH_BODY;
        end else if (ch == pecp_pkg::CH_DOT) begin
          echo       = 1'b1;
          phase_next = PH_DOT;
        end else begin
          do_fail = 1'b1;
        end
      end
      PH_FIRSTCHAR: begin
        if (pecp_pkg::is_alpha(ch) || ch == pecp_pkg::CH_UNDER) begin
          echo       = 1'b1;
          phase_next = PH_BODY;
        end else begin
          do_fail = 1'b1;
        end
      end
      PH_BODY: begin
        if (pecp_pkg::is_alpha(ch) || pecp_pkg::is_digit(ch) ||
            ch == pecp_pkg::CH_UNDER || ch == pecp_pkg::CH_DOT) begin
          echo = 1'b1;
        end else if (ch == pecp_pkg::CH_LBRACK) begin
          phase_next = PH_OPEN;
        end else begin
          do_fail = 1'b1;
        end
      end
      PH_DOT: begin
        if (ch == pecp_pkg::CH_DOT) begin
          echo       = 1'b1;
          phase_next = PH_DONE;
        end else begin
          do_fail = 1'b1;
        end
      end
      PH_OPEN: begin
        if (ch == pecp_pkg::CH_RBRACK) begin
          mode_next  = pecp_pkg::MODE_APPEND;
          phase_next = PH_DONE;
        end else if (ch == pecp_pkg::CH_DOLLAR) begin
          mode_next  = pecp_pkg::MODE_TAIL;
          phase_next = PH_CLOSE;
        end else if (ch == pecp_pkg::CH_ZERO) begin
          index_acc_next = '0;
          mode_next      = pecp_pkg::MODE_INDEX;
          phase_next     = PH_BASE;
        end else if (pecp_pkg::is_digit(ch)) begin
          radix_next     = RADIX_DEC;
          mode_next      = pecp_pkg::MODE_INDEX;
          index_acc_next = INDEX_BITS'(ch[3:0]);
          phase_next     = PH_INDEX;
        end else begin
          do_fail = 1'b1;
        end
      end
      PH_CLOSE: begin
        if (ch == pecp_pkg::CH_RBRACK) begin
          phase_next = PH_DONE;
        end else begin
          do_fail = 1'b1;
        end
      end
      PH_BASE: begin
        if (ch == pecp_pkg::CH_X) begin
          radix_next = RADIX_HEX;
          phase_next = PH_INDEX;
        end else if ((ch >= pecp_pkg::CH_ZERO) && (ch <= pecp_pkg::CH_SEVEN)) begin
          // accumulator is zero here, so the sum is just the digit
          radix_next     = RADIX_OCT;
          index_acc_next = INDEX_BITS'(ch[2:0]);
          phase_next     = PH_INDEX;
        end else if (ch == pecp_pkg::CH_RBRACK) begin
          radix_next = RADIX_DEC;
          phase_next = PH_DONE;
        end else begin
          do_fail = 1'b1;
        end
      end
      PH_INDEX: begin
        if (dig_ok) begin
          if (acc_ovf) begin
            do_fail   = 1'b1;
            fail_code = pecp_pkg::ST_OVERFLOW;
          end else begin
            index_acc_next = acc_sum[INDEX_BITS-1:0];
          end
        end else if (ch == pecp_pkg::CH_RBRACK) begin
          phase_next = PH_DONE;
        end else begin
          do_fail = 1'b1;
        end
      end
      PH_DONE: do_fail = 1'b1;
      default: phase_next = PH_HALT;
    endcase

    // First error sticks
    if (do_fail) begin
      phase_next = PH_HALT;
      if (error_code == pecp_pkg::ST_OK) begin
        error_next = fail_code;
      end
    end

    name_seen_next = name_seen | echo;

    // End of element: finish the status, then restart
    if (last && error_next == pecp_pkg::ST_OK && !name_seen_next) begin
      error_next = pecp_pkg::ST_EMPTY;
    end
  end

  // Summary fields; all but the status stay zero unless the element ended cleanly
  always_comb begin
    acc_wide     = 64'(index_acc_next);
    res_status   = 2'(error_next);
    res_bookmark = 1'b0;
    res_mode     = 2'(pecp_pkg::MODE_NONE);
    res_index    = '0;
    if (error_next == pecp_pkg::ST_OK) begin
      res_bookmark = bookmark_next;
      res_mode     = 2'(mode_next);
      if (mode_next == pecp_pkg::MODE_INDEX) begin
        res_index = acc_wide[31:0];
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      radix        <= RADIX_DEC;
      index_acc    <= '0;
      mode_reg     <= pecp_pkg::MODE_NONE;
      bookmark_reg <= 1'b0;
      name_seen    <= 1'b0;
      error_code   <= pecp_pkg::ST_OK;
    end else if (accept) begin
      if (last) begin
        phase        <= PH_START;
        radix        <= RADIX_DEC;
        index_acc    <= '0;
        mode_reg     <= pecp_pkg::MODE_NONE;
        bookmark_reg <= 1'b0;
        name_seen    <= 1'b0;
        error_code   <= pecp_pkg::ST_OK;
      end else begin
        phase        <= phase_next;
        radix        <= radix_next;
        index_acc    <= index_acc_next;
        mode_reg     <= mode_next;
        bookmark_reg <= bookmark_next;
        name_seen    <= name_seen_next;
        error_code   <= error_next;
      end
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      name_valid  <= echo;
      name_char   <= echo ? ch : 8'h00;
      done_res    <= last;
      status      <= last ? res_status : 2'(pecp_pkg::ST_OK);
      bookmark    <= last & res_bookmark;
      suffix_mode <= last ? res_mode : 2'(pecp_pkg::MODE_NONE);
      index_value <= last ? res_index : 32'h0;
    end
  end

endmodule

/* rtl/pecp_checker.sv */
// Port-level checker for the path element parser and its bind to the top level.
module pecp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  ch,
  input logic        last,
  input logic        out_valid,
  input logic        out_stall,
  input logic        name_valid,
  input logic [7:0]  name_char,
  input logic        done_res,
  input logic [1:0]  status,
  input logic        bookmark,
  input logic [1:0]  suffix_mode,
  input logic [31:0] index_value
);

  // Every accepted word yields a result word on the next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted word produced no result");

  // Summary fields stay zero on words that do not end an element
  a_mid_summary_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !done_res) |->
      (status == 2'(pecp_pkg::ST_OK) && !bookmark &&
       suffix_mode == 2'(pecp_pkg::MODE_NONE) && index_value == 32'h0))
    else $error("summary fields set on a mid-element word");

  // A failed element reports nothing but its status
  a_fail_summary_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res && status != 2'(pecp_pkg::ST_OK)) |->
      (!bookmark && suffix_mode == 2'(pecp_pkg::MODE_NONE) && index_value == 32'h0))
    else $error("summary fields set on a failed element");

  // Index only carried in index mode; name byte only with name_valid
  a_index_and_name: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      ((suffix_mode == 2'(pecp_pkg::MODE_INDEX) || index_value == 32'h0) &&
       (name_valid || name_char == 8'h00)))
    else $error("index or name byte set outside its mode");

  // A stalled result word holds
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(name_char) && $stable(status) && $stable(index_value)))
    else $error("stalled result word changed");

endmodule

bind path_element_char_parser_unit pecp_checker u_pecp_checker (.*);

/* tb/path_element_char_parser_checker.sv */
// Checker for the path element parser: predicts each result word and compares it.
`timescale 1ns / 1ps

module path_element_char_parser_checker #(
  parameter int INDEX_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  ch,
  input  logic        last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        name_valid,
  input  logic [7:0]  name_char,
  input  logic        done_res,
  input  logic [1:0]  status,
  input  logic        bookmark,
  input  logic [1:0]  suffix_mode,
  input  logic [31:0] index_value,
  output int          errors,
  output int          pending
);

  localparam logic [63:0] IDX_MAX = (INDEX_BITS >= 64) ? '1 : ((64'd1 << INDEX_BITS) - 64'd1);

  typedef enum logic [3:0] {
    P_START, P_FIRST, P_BODY, P_DOT, P_OPEN, P_CLOSE, P_BASE, P_INDEX, P_DONE, P_HALT
  } parse_phase_t;

  typedef enum logic [1:0] {R_DEC, R_OCT, R_HEX} radix_t;

  typedef struct packed {
    logic                 name_valid;
    logic [7:0]           name_char;
    logic                 done_res;
    pecp_pkg::status_t    status;
    logic                 bookmark;
    pecp_pkg::mode_t      suffix_mode;
    logic [31:0]          index_value;
  } parse_word_t;

  // Predictor state
  parse_phase_t      ph;
  radix_t            rdx;
  logic [63:0]       acc;
  pecp_pkg::mode_t   mode;
  logic              bmk;
  logic              seen;
  pecp_pkg::status_t err;

  parse_word_t  expected_words[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic logic letter(input logic [7:0] c);
    return (c >= pecp_pkg::CH_LA && c <= pecp_pkg::CH_LZ) ||
           (c >= pecp_pkg::CH_UA && c <= pecp_pkg::CH_UZ);
  endfunction

  function automatic logic dec_digit(input logic [7:0] c);
    return c >= pecp_pkg::CH_ZERO && c <= pecp_pkg::CH_NINE;
  endfunction

  function automatic logic oct_digit(input logic [7:0] c);
    return c >= pecp_pkg::CH_ZERO && c <= pecp_pkg::CH_SEVEN;
  endfunction

  function automatic void clear_parse();
    ph   = P_START;
    rdx  = R_DEC;
    acc  = '0;
    mode = pecp_pkg::MODE_NONE;
    bmk  = 1'b0;
    seen = 1'b0;
    err  = pecp_pkg::ST_OK;
  endfunction

  // First error wins; the element then ignores everything up to last
  function automatic void halt(input pecp_pkg::status_t code);
    if (err == pecp_pkg::ST_OK) err = code;
    ph = P_HALT;
  endfunction

  function automatic void add_digit(input logic [63:0] base, input logic [63:0] d);
    if (acc > (IDX_MAX - d) / base) halt(pecp_pkg::ST_OVERFLOW);
    else acc = acc * base + d;
  endfunction

  // One character through the element grammar
  function automatic parse_word_t parse_char(input logic [7:0] c, input logic fin);
    parse_word_t w;
    logic        echo;
    echo = 1'b0;
    case (ph)
      P_START: begin
        if (c == pecp_pkg::CH_PERCENT) begin
          echo = 1'b1; ph = P_FIRST;
        end else if (c == pecp_pkg::CH_DOLLAR) begin
          bmk = 1'b1; ph = P_FIRST;
        end else if (letter(c) || c == pecp_pkg::CH_UNDER) begin
          echo = 1'b1; ph = P_BODY;
        end else if (c == pecp_pkg::CH_DOT) begin
          echo = 1'b1; ph = P_DOT;
        end else halt(pecp_pkg::ST_SYNTAX);
      end
      P_FIRST: begin
        if (letter(c) || c == pecp_pkg::CH_UNDER) begin
          echo = 1'b1; ph = P_BODY;
        end else halt(pecp_pkg::ST_SYNTAX);
      end
      P_BODY: begin
        if (letter(c) || dec_digit(c) || c == pecp_pkg::CH_UNDER || c == pecp_pkg::CH_DOT)
          echo = 1'b1;
        else if (c == pecp_pkg::CH_LBRACK) ph = P_OPEN;
        else halt(pecp_pkg::ST_SYNTAX);
      end
      P_DOT: begin
        if (c == pecp_pkg::CH_DOT) begin
          echo = 1'b1; ph = P_DONE;
        end else halt(pecp_pkg::ST_SYNTAX);
      end
      P_OPEN: begin
        if (c == pecp_pkg::CH_RBRACK) begin
          mode = pecp_pkg::MODE_APPEND; ph = P_DONE;
        end else if (c == pecp_pkg::CH_DOLLAR) begin
          mode = pecp_pkg::MODE_TAIL; ph = P_CLOSE;
        end else if (c == pecp_pkg::CH_ZERO) begin
          acc = '0; mode = pecp_pkg::MODE_INDEX; ph = P_BASE;
        end else if (dec_digit(c)) begin
          rdx  = R_DEC;
          mode = pecp_pkg::MODE_INDEX;
          acc  = 64'(c - pecp_pkg::CH_ZERO);
          ph   = P_INDEX;
        end else halt(pecp_pkg::ST_SYNTAX);
      end
      P_CLOSE: begin
        if (c == pecp_pkg::CH_RBRACK) ph = P_DONE;
        else halt(pecp_pkg::ST_SYNTAX);
      end
      P_BASE: begin
        if (c == pecp_pkg::CH_X) begin
          rdx = R_HEX; ph = P_INDEX;
        end else if (oct_digit(c)) begin
          rdx = R_OCT; acc = acc + 64'(c - pecp_pkg::CH_ZERO); ph = P_INDEX;
        end else if (c == pecp_pkg::CH_RBRACK) begin
          rdx = R_DEC; ph = P_DONE;
        end else halt(pecp_pkg::ST_SYNTAX);
      end
      P_INDEX: begin
        if (rdx == R_DEC && dec_digit(c)) add_digit(64'd10, 64'(c - pecp_pkg::CH_ZERO));
        else if (rdx == R_OCT && oct_digit(c))
          add_digit(64'd8, 64'(c - pecp_pkg::CH_ZERO));
        else if (rdx == R_HEX && dec_digit(c))
          add_digit(64'd16, 64'(c - pecp_pkg::CH_ZERO));
        else if (rdx == R_HEX && c >= pecp_pkg::CH_LA && c <= pecp_pkg::CH_LF)
          add_digit(64'd16, 64'(c - pecp_pkg::CH_LA) + 64'd10);
        else if (rdx == R_HEX && c >= pecp_pkg::CH_UA && c <= pecp_pkg::CH_UF)
          add_digit(64'd16, 64'(c - pecp_pkg::CH_UA) + 64'd10);
        else if (c == pecp_pkg::CH_RBRACK) ph = P_DONE;
        else halt(pecp_pkg::ST_SYNTAX);
      end
      P_DONE:  halt(pecp_pkg::ST_SYNTAX);
      default: ph = P_HALT;
    endcase

    if (echo) seen = 1'b1;

    w = '0;
    w.name_valid = echo;
    w.name_char  = echo ? c : 8'd0;
    w.done_res   = fin;
    if (fin) begin
      if (err == pecp_pkg::ST_OK && !seen) err = pecp_pkg::ST_EMPTY;
      w.status = err;
      if (err == pecp_pkg::ST_OK) begin
        w.bookmark    = bmk;
        w.suffix_mode = mode;
        w.index_value = (mode == pecp_pkg::MODE_INDEX) ? acc[31:0] : 32'd0;
      end
      clear_parse();
    end
    return w;
  endfunction

  function automatic int check_field(input string fld, input logic [31:0] want,
                                     input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Watch both channels; results are retired before new words are queued
  always @(posedge clk) begin : watch
    parse_word_t w;
    int          bad;
    bad = 0;
    if (rst) begin
      clear_parse();
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result word with nothing expected, expected none, actual %0h",
                   $time, {name_valid, name_char, done_res, status, bookmark, suffix_mode,
                           index_value});
          bad++;
        end else begin
          w = expected_words.pop_front();
          bad += check_field("name_valid", 32'(w.name_valid), 32'(name_valid));
          bad += check_field("name_char", 32'(w.name_char), 32'(name_char));
          bad += check_field("done_res", 32'(w.done_res), 32'(done_res));
          bad += check_field("status", 32'(w.status), 32'(status));
          bad += check_field("bookmark", 32'(w.bookmark), 32'(bookmark));
          bad += check_field("suffix_mode", 32'(w.suffix_mode), 32'(suffix_mode));
          bad += check_field("index_value", w.index_value, index_value);
        end
      end
      if (in_valid && !in_stall) expected_words = {expected_words, parse_char(ch, last)};
    end
    errors  <= errors + bad;
    pending <= expected_words.size();
  end

endmodule

/* tb/path_element_char_parser_unit_tb.sv */
// Testbench top for the path element parser: stimulus, stalls and the verdict.
`timescale 1ns / 1ps

module path_element_char_parser_unit_tb;

  localparam int LIMIT_CYCLES = 200000;
  localparam int RAND_WORDS   = 400;
  localparam string FIRST_SET = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string BODY_SET  =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789.";

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  ch;
  logic        last;
  logic        out_valid;
  logic        out_stall;
  logic        name_valid;
  logic [7:0]  name_char;
  logic        done_res;
  logic [1:0]  status;
  logic        bookmark;
  logic [1:0]  suffix_mode;
  logic [31:0] index_value;
  int          errors;
  int          pending;

  logic        calm;          // no idling on either side while set
  logic [7:0]  elem_q[$];     // characters of the element being built
  int          words_sent;
  int          cycles = 0;

  path_element_char_parser_unit #(.INDEX_BITS(32)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .ch(ch), .last(last),
    .out_valid(out_valid), .out_stall(out_stall),
    .name_valid(name_valid), .name_char(name_char), .done_res(done_res),
    .status(status), .bookmark(bookmark), .suffix_mode(suffix_mode),
    .index_value(index_value)
  );

  path_element_char_parser_checker #(.INDEX_BITS(32)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .ch(ch), .last(last),
    .out_valid(out_valid), .out_stall(out_stall),
    .name_valid(name_valid), .name_char(name_char), .done_res(done_res),
    .status(status), .bookmark(bookmark), .suffix_mode(suffix_mode),
    .index_value(index_value),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("path_element_char_parser_unit_tb: done, errors");
      $finish;
    end
  end

  // Receiver stalls
  always @(posedge clk) begin
    if (rst || calm) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 12);
  end

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  task automatic add_char(input logic [7:0] c);
    elem_q = {elem_q, c};
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  // One word; returns at the edge that accepts it, valid still high
  task automatic send_word(input logic [7:0] c, input logic fin);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 12) gap = $urandom_range(1, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    ch       <= c;
    last     <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_elem();
    for (int i = 0; i < elem_q.size(); i++) send_word(elem_q[i], i == elem_q.size() - 1);
    words_sent += elem_q.size();
    elem_q.delete();
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic push_name();
    int n;
    n = $urandom_range(0, 5);
    add_char(pick(FIRST_SET));
    repeat (n) add_char(pick(BODY_SET));
  endtask

  // Index text in decimal, octal or hex, biased toward the overflow boundary
  task automatic push_index_text();
    logic [39:0] v;
    string       s;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 20);
      1: v = 40'hFF_FFFF_FFFF >> 8;
      2: v = 40'h1_0000_0000 + $urandom_range(0, 20);
      3: v = 40'hFFFF_FFFF - $urandom_range(0, 20);
      4: v = {8'd0, $urandom};
      default: v = {4'd0, 4'($urandom), $urandom};
    endcase
    case ($urandom_range(0, 2))
      0: s = $sformatf("%0d", v);
      1: s = {"0", $sformatf("%0o", v)};
      default: begin
        s = $sformatf("%0h", v);
        for (int i = 0; i < s.len(); i++)
          if (s[i] >= pecp_pkg::CH_LA && $urandom_range(0, 1)) s[i] = s[i] - 8'd32;
        s = {"0x", s};
      end
    endcase
    push_str(s);
  endtask

  // Mostly well-formed element with random content; a bracket may be left open
  task automatic push_good();
    int k;
    k = $urandom_range(0, 9);
    if (k < 2) add_char(pecp_pkg::CH_PERCENT);
    else if (k < 4) add_char(pecp_pkg::CH_DOLLAR);
    push_name();
    case ($urandom_range(0, 5))
      0: ;
      1: begin
        if ($urandom_range(0, 7) == 0) add_char(pecp_pkg::CH_LBRACK);
        else push_str("[]");
      end
      2: push_str("[$]");
      default: begin
        add_char(pecp_pkg::CH_LBRACK);
        push_index_text();
        if ($urandom_range(0, 9) != 0) add_char(pecp_pkg::CH_RBRACK);
      end
    endcase
  endtask

  task automatic push_random_elem();
    int k;
    int n;
    k = $urandom_range(0, 99);
    if (k < 50) push_good();
    else if (k < 60) begin
      if ($urandom_range(0, 1)) push_str("..");
      else push_str(".");
    end else if (k < 68) begin
      if ($urandom_range(0, 1)) add_char(pecp_pkg::CH_DOLLAR);
      else add_char(pecp_pkg::CH_PERCENT);
    end else if (k < 85) begin
      // broken: one character replaced, or a stray one appended
      push_good();
      if ($urandom_range(0, 1)) elem_q[$urandom_range(0, elem_q.size() - 1)] = 8'($urandom);
      else add_char(8'($urandom));
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) add_char(8'($urandom));
    end
  endtask

  initial begin
    logic paused;
    paused     = 1'b0;
    words_sent = 0;
    rst       <= 1'b1;
    calm      <= 1'b0;
    in_valid  <= 1'b0;
    ch        <= 8'd0;
    last      <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: each mode, prefixes, empty name, dot entries, byte extremes,
    // a character after a complete element
    push_str("%a[9]");   send_elem();
    push_str("$");       send_elem();
    push_str("..");      send_elem();
    push_str("x[]");     send_elem();
    push_str("$y[$]");   send_elem();
    push_str("a[0xfF]"); send_elem();
    add_char(8'hFF);     send_elem();
    add_char(8'h00);     send_elem();
    push_str("..a");     send_elem();

    // Random elements, with a calm stretch and one full drain midway
    words_sent = 0;
    while (words_sent < RAND_WORDS) begin
      calm <= (words_sent >= 120 && words_sent < 220);
      if (!paused && words_sent >= 250) begin
        paused = 1'b1;
        drain();
      end
      push_random_elem();
      send_elem();
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("path_element_char_parser_unit_tb: done, clean");
    else
      $display("path_element_char_parser_unit_tb: done, errors");
    $finish;
  end

endmodule

/* files.f */
rtl/pecp_pkg.sv
rtl/path_element_char_parser_unit.sv
rtl/pecp_checker.sv
tb/path_element_char_parser_checker.sv
tb/path_element_char_parser_unit_tb.sv
